@@ hw/rtl/multi_device_coherence_lock_tracker_defines.svh @@
// ----------------------------------------------------------------------------
// Multi-device coherence lock tracker: assertion macros
// Shared property macros for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef MULTI_DEVICE_COHERENCE_LOCK_TRACKER_DEFINES_SVH
`define MULTI_DEVICE_COHERENCE_LOCK_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MDCLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MDCLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mdclt_pkg.sv @@
// ----------------------------------------------------------------------------
// mdclt_pkg
// Constants, codes and shared types of the coherence lock tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mdclt_pkg;

	localparam int NUM_DEVICES     = 8;	// 2 .. 8
	localparam int READ_COUNT_BITS = 8;	// 2 .. 16
	localparam int DEV_W           = $clog2(NUM_DEVICES);

	typedef enum logic [2:0] {
		CMD_RLOCK   = 3'd0,
		CMD_RUNLOCK = 3'd1,
		CMD_WLOCK   = 3'd2,
		CMD_WUNLOCK = 3'd3,
		CMD_UNCACHE = 3'd4,
		CMD_SETMODE = 3'd5
	} cmd_e_t;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_WLOCKED     = 3'd1,
		STS_LOCKED      = 3'd2,
		STS_NOT_VALID   = 3'd3,
		STS_MISMATCH    = 3'd4,
		STS_UNSUPPORTED = 3'd5,
		STS_REFUSED     = 3'd6,
		STS_OVERFLOW    = 3'd7
	} status_e_t;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_ALLOC = 3'd1,
		ACT_FILL  = 3'd2,
		ACT_COPY  = 3'd3,
		ACT_FREE  = 3'd4
	} action_e_t;

	typedef enum logic [1:0] {
		MODE_UNINIT  = 2'd0,
		MODE_UNIFORM = 2'd1,
		MODE_DATA    = 2'd2
	} mode_e_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;	// latch the incoming transaction
		logic commit;	// evaluate, update tracking state, load result register
	} ctl_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/mdclt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mdclt_ctrl
// Two-state sequencer and result-register valid for the lock tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module mdclt_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire                  out_stall,
	output mdclt_pkg::ctl_cmd_t  cmd_o
);
	import mdclt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		cmd_o.capture  = in_valid && (state_q == ST_IDLE);
		// result register is free, or drains this very edge
		cmd_o.commit   = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
		state_d        = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_o.capture)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd_o.commit)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_o.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/mdclt_dp.sv @@
// ----------------------------------------------------------------------------
// mdclt_dp
// Per-device tracking state, command evaluation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdclt_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  mdclt_pkg::ctl_cmd_t  cmd_i,
	input  wire  [2:0]           cmd,
	input  wire  [2:0]           dev,
	input  wire                  new_mode,
	output logic [2:0]           status,
	output logic [2:0]           action,
	output logic                 need_alloc,
	output logic [2:0]           src_dev,
	output logic [2:0]           dst_dev
);
	import mdclt_pkg::*;

	// captured transaction
	logic [2:0] cmd_q;
	logic [2:0] dev_q;
	logic       nm_q;

	// result register
	logic [2:0] status_q;
	logic [2:0] action_q;
	logic       need_alloc_q;
	logic [2:0] src_dev_q;
	logic [2:0] dst_dev_q;

	// tracking state
	mode_e_t                    mode_q, mode_n;
	logic [NUM_DEVICES-1:0]     cv_q, cv_n;	// copy valid
	logic [NUM_DEVICES-1:0]     al_q, al_n;	// arrays allocated
	logic [NUM_DEVICES-1:0]     wl_q, wl_n;	// write locked
	logic [READ_COUNT_BITS-1:0] rc_q [NUM_DEVICES];
	logic [READ_COUNT_BITS-1:0] rc_n [NUM_DEVICES];

	// evaluation
	logic [DEV_W-1:0]       di;
	logic                   dev_ok;
	logic [NUM_DEVICES-1:0] dev_oh;
	logic                   any_wl, any_lock, other_valid;
	logic [DEV_W-1:0]       hi_valid, src_sel;
	logic                   mv_fresh;
	status_e_t              mv_st, st;
	action_e_t              mv_act, act;
	logic                   mv_na, na;
	logic [DEV_W-1:0]       mv_src, src;
	logic [READ_COUNT_BITS-1:0] rc_base;

	always_comb begin
		di       = DEV_W'(dev_q);
		dev_ok   = (32'(dev_q) < NUM_DEVICES);
		dev_oh   = NUM_DEVICES'(1) << di;
		any_wl   = |wl_q;
		any_lock = any_wl;
		hi_valid = '0;
		for (int i = 0; i < NUM_DEVICES; i++) begin
			if (rc_q[i] != '0)
				any_lock = 1'b1;
			if (cv_q[i])
				hi_valid = DEV_W'(i);
		end
		src_sel     = cv_q[0] ? '0 : hi_valid;
		other_valid = |(cv_q & ~dev_oh);

		// bring copy di up to date
		mv_st  = STS_OK;
		mv_act = ACT_NONE;
		mv_na  = 1'b0;
		mv_src = '0;
		if (!cv_q[di]) begin
			case (mode_q)
				MODE_DATA: begin
					if (cv_q == '0)
						mv_st = STS_NOT_VALID;
					else if (src_sel != '0 && di != '0)
						mv_st = STS_UNSUPPORTED;
					else begin
						mv_act = ACT_COPY;
						mv_src = src_sel;
					end
				end
				MODE_UNIFORM: mv_act = ACT_FILL;
				default:      mv_act = ACT_ALLOC;
			endcase
			if (mv_st == STS_OK)
				mv_na = !al_q[di];
		end
		mv_fresh = !cv_q[di] && (mv_st == STS_OK);
		rc_base  = mv_fresh ? '0 : rc_q[di];

		st     = STS_OK;
		act    = ACT_NONE;
		na     = 1'b0;
		src    = '0;
		mode_n = mode_q;
		cv_n   = cv_q;
		al_n   = al_q;
		wl_n   = wl_q;
		rc_n   = rc_q;

		if (cmd_q == CMD_SETMODE) begin
			if (any_lock)
				st = STS_REFUSED;
			else begin
				mode_n = nm_q ? MODE_UNIFORM : MODE_UNINIT;
				cv_n   = '0;
			end
		end else if (!dev_ok) begin
			st = STS_REFUSED;
		end else begin
			case (cmd_q)
				CMD_RLOCK: begin
					if (any_wl)
						st = STS_WLOCKED;
					else if (&rc_q[di])
						st = STS_OVERFLOW;
					else if (mv_st != STS_OK)
						st = mv_st;
					else begin
						act = mv_act;
						na  = mv_na;
						src = mv_src;
						if (mv_fresh) begin
							al_n[di] = 1'b1;
							cv_n[di] = 1'b1;
							wl_n[di] = 1'b0;
						end
						rc_n[di] = rc_base + READ_COUNT_BITS'(1);
					end
				end
				CMD_RUNLOCK: begin
					if (!cv_q[di])
						st = STS_NOT_VALID;
					else if (rc_q[di] == '0 || wl_q[di])
						st = STS_MISMATCH;
					else
						rc_n[di] = rc_q[di] - READ_COUNT_BITS'(1);
				end
				CMD_WLOCK: begin
					if (any_lock)
						st = STS_LOCKED;
					else if (mv_st != STS_OK)
						st = mv_st;
					else begin
						act      = mv_act;
						na       = mv_na;
						src      = mv_src;
						al_n[di] = 1'b1;
						if (mv_fresh)
							rc_n[di] = '0;
						wl_n[di] = 1'b1;
						cv_n     = dev_oh;	// this copy only
						mode_n   = MODE_DATA;
					end
				end
				CMD_WUNLOCK: begin
					if (!cv_q[di])
						st = STS_NOT_VALID;
					else if (rc_q[di] != '0 || !wl_q[di])
						st = STS_MISMATCH;
					else
						wl_n[di] = 1'b0;
				end
				CMD_UNCACHE: begin
					if (rc_q[di] != '0 || wl_q[di])
						st = STS_LOCKED;
					else if (mode_q == MODE_DATA && !other_valid)
						st = STS_NOT_VALID;
					else begin
						cv_n[di] = 1'b0;
						act      = al_q[di] ? ACT_FREE : ACT_NONE;
						al_n[di] = 1'b0;
					end
				end
				default: st = STS_REFUSED;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.capture) begin
			cmd_q <= cmd;
			dev_q <= dev;
			nm_q  <= new_mode;
		end
		if (cmd_i.commit) begin
			status_q     <= st;
			action_q     <= act;
			need_alloc_q <= na;
			src_dev_q    <= 3'(src);
			dst_dev_q    <= (act != ACT_NONE) ? dev_q : 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UNINIT;
			cv_q   <= '0;
			al_q   <= '0;
			wl_q   <= '0;
			for (int i = 0; i < NUM_DEVICES; i++)
				rc_q[i] <= '0;
		end else if (cmd_i.commit) begin
			mode_q <= mode_n;
			cv_q   <= cv_n;
			al_q   <= al_n;
			wl_q   <= wl_n;
			rc_q   <= rc_n;
		end
	end

	assign status     = status_q;
	assign action     = action_q;
	assign need_alloc = need_alloc_q;
	assign src_dev    = src_dev_q;
	assign dst_dev    = dst_dev_q;

endmodule

`default_nettype wire

@@ hw/rtl/multi_device_coherence_lock_tracker.sv @@
// Usage: one buffer with copies on up to NUM_DEVICES devices (device 0 is the CPU).
// Input channel (in_valid/in_stall): a transaction carries cmd, dev and new_mode.
// Output channel (out_valid/out_stall): exactly one result transaction per input
//   transaction, in order: status, action, need_alloc, src_dev, dst_dev.
// Flow: a transaction taken from the input is held in the capture register, then
//   evaluated and loaded into the result register when that register is free,
//   from which the output takes it. A new input transaction is not taken until
//   the last one is loaded (controller's capture / evaluate sequence); evaluation
//   scans all device entries and updates the tracking state in one step.
// Stall: the result register holds its transaction while out_stall is high; one
//   further input transaction is taken and parked until the register frees.
// Reset (arst_n low): mode uninitialized, all valid/allocated/lock state cleared,
//   no result pending, input ready.
// ----------------------------------------------------------------------------
// multi_device_coherence_lock_tracker
// Top level: coherence and lock bookkeeping for one multi-device buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_device_coherence_lock_tracker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [2:0] cmd,
	input  wire  [2:0] dev,
	input  wire        new_mode,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [2:0] status,
	output logic [2:0] action,
	output logic       need_alloc,
	output logic [2:0] src_dev,
	output logic [2:0] dst_dev
);
	import mdclt_pkg::*;

	ctl_cmd_t ctl_cmd;

	// sequencer: owns both handshakes
	mdclt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd_o     (ctl_cmd)
	);

	// tracking state, checks and the result register
	mdclt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_i      (ctl_cmd),
		.cmd        (cmd),
		.dev        (dev),
		.new_mode   (new_mode),
		.status     (status),
		.action     (action),
		.need_alloc (need_alloc),
		.src_dev    (src_dev),
		.dst_dev    (dst_dev)
	);

endmodule

`default_nettype wire

@@ hw/rtl/mdclt_chk.sv @@
// ----------------------------------------------------------------------------
// mdclt_chk
// Port-level checks for the coherence lock tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_device_coherence_lock_tracker_defines.svh"

module mdclt_chk (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire [2:0] cmd,
	input wire [2:0] dev,
	input wire       new_mode,
	input wire       out_valid,
	input wire       out_stall,
	input wire [2:0] status,
	input wire [2:0] action,
	input wire       need_alloc,
	input wire [2:0] src_dev,
	input wire [2:0] dst_dev
);
	import mdclt_pkg::*;

	// one transaction in evaluation: input closes right after a take
	`MDCLT_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall, "input taken back to back")

	// with an empty result register a take goes through capture and evaluation, then is offered
	`MDCLT_ASSERT_NXT(a_latency, clk, arst_n, in_valid && !in_stall && !out_valid, !out_valid ##1 out_valid, "result latency wrong")

	// failed check carries no action
	`MDCLT_ASSERT_IMP(a_fail_clean, clk, arst_n, out_valid && status != STS_OK, action == ACT_NONE && !need_alloc && src_dev == 3'd0 && dst_dev == 3'd0, "failed result not cleared")

	// a stalled result stays offered
	`MDCLT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(dst_dev), "stalled result dropped")

endmodule

bind multi_device_coherence_lock_tracker mdclt_chk u_chk (.*);

`default_nettype wire

@@ sim/mdclt_lock_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdclt_lock_checker
// Watches both channels of the coherence lock tracker. It keeps its own copy
// of the per-device valid, allocation and lock state and predicts every result.
// Each result is compared field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module mdclt_lock_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_stall,
	input  wire  [2:0] cmd,
	input  wire  [2:0] dev,
	input  wire        new_mode,
	input  wire        out_valid,
	input  wire        out_stall,
	input  wire  [2:0] status,
	input  wire  [2:0] action,
	input  wire        need_alloc,
	input  wire  [2:0] src_dev,
	input  wire  [2:0] dst_dev,
	output int         fail_count,
	output int         results_owed
);
	import mdclt_pkg::*;

	localparam logic [READ_COUNT_BITS-1:0] RCOUNT_MAX = '1;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		status_e_t  status;
		action_e_t  action;
		logic       need_alloc;
		logic [2:0] src_dev;
		logic [2:0] dst_dev;
	} lock_result_t;

	mode_e_t                    mode_q;
	logic [NUM_DEVICES-1:0]     valid_q;
	logic [NUM_DEVICES-1:0]     alloc_q;
	logic [NUM_DEVICES-1:0]     wlock_q;
	logic [READ_COUNT_BITS-1:0] rcount_q [NUM_DEVICES];
	lock_result_t               awaited_results [$];
	lock_result_t               head, fresh;
	int                         mismatches = 0;

	function automatic logic lock_held();
		logic held;
		int i;
		held = |wlock_q;
		for (i = 0; i < NUM_DEVICES; i++)
			if (rcount_q[i] != '0) held = 1'b1;
		return held;
	endfunction

	// bring copy d up to date before a lock; state only changes on success
	task automatic ensure_copy(input int d, output status_e_t st, output action_e_t act,
			output logic na, output logic [2:0] src);
		int s, i;
		logic found;
		st = STS_OK; act = ACT_NONE; na = 1'b0; src = '0;
		s = 0; found = 1'b0;
		if (!valid_q[d]) begin
			if (mode_q == MODE_DATA) begin
				// CPU wins as source, else the highest valid device
				if (valid_q[0]) found = 1'b1;
				else
					for (i = 0; i < NUM_DEVICES; i++)
						if (valid_q[i]) begin
							s = i;
							found = 1'b1;
						end
				if (!found) st = STS_NOT_VALID;
				else if (s != 0 && d != 0) st = STS_UNSUPPORTED;
				else begin
					act = ACT_COPY;
					src = 3'(s);
				end
			end else if (mode_q == MODE_UNIFORM) act = ACT_FILL;
			else act = ACT_ALLOC;
			if (st == STS_OK) begin
				na = !alloc_q[d];
				alloc_q[d] = 1'b1;
				valid_q[d] = 1'b1;
				rcount_q[d] = '0;
				wlock_q[d] = 1'b0;
			end
		end
	endtask

	task automatic predict_lock_outcome(input logic [2:0] c, input logic [2:0] d_in,
			input logic m, output lock_result_t r);
		int d, i;
		logic other;
		status_e_t st;
		action_e_t act;
		logic na;
		logic [2:0] src;
		d = int'(d_in);
		st = STS_OK; act = ACT_NONE; na = 1'b0; src = '0; other = 1'b0;
		if (c != CMD_SETMODE && d >= NUM_DEVICES) st = STS_REFUSED;
		else case (c)
			CMD_SETMODE: begin
				if (lock_held()) st = STS_REFUSED;
				else begin
					mode_q = mode_e_t'({1'b0, m});
					valid_q = '0;
				end
			end
			CMD_RLOCK: begin
				if (|wlock_q) st = STS_WLOCKED;
				else if (rcount_q[d] == RCOUNT_MAX) st = STS_OVERFLOW;
				else begin
					ensure_copy(d, st, act, na, src);
					if (st == STS_OK) rcount_q[d] = rcount_q[d] + READ_COUNT_BITS'(1);
				end
			end
			CMD_RUNLOCK: begin
				if (!valid_q[d]) st = STS_NOT_VALID;
				else if (rcount_q[d] == '0 || wlock_q[d]) st = STS_MISMATCH;
				else rcount_q[d] = rcount_q[d] - READ_COUNT_BITS'(1);
			end
			CMD_WLOCK: begin
				if (lock_held()) st = STS_LOCKED;
				else begin
					ensure_copy(d, st, act, na, src);
					if (st == STS_OK) begin
						wlock_q[d] = 1'b1;
						valid_q = '0;
						valid_q[d] = 1'b1;
						mode_q = MODE_DATA;
					end
				end
			end
			CMD_WUNLOCK: begin
				if (!valid_q[d]) st = STS_NOT_VALID;
				else if (rcount_q[d] != '0 || !wlock_q[d]) st = STS_MISMATCH;
				else wlock_q[d] = 1'b0;
			end
			CMD_UNCACHE: begin
				if (rcount_q[d] != '0 || wlock_q[d]) st = STS_LOCKED;
				else begin
					for (i = 0; i < NUM_DEVICES; i++)
						if (i != d && valid_q[i]) other = 1'b1;
					// last copy of real data may not be dropped
					if (mode_q == MODE_DATA && !other) st = STS_NOT_VALID;
					else begin
						valid_q[d] = 1'b0;
						if (alloc_q[d]) act = ACT_FREE;
						alloc_q[d] = 1'b0;
					end
				end
			end
			default: st = STS_REFUSED;
		endcase
		if (st != STS_OK) begin
			act = ACT_NONE; na = 1'b0; src = '0;
		end
		r.status     = st;
		r.action     = act;
		r.need_alloc = na;
		r.src_dev    = src;
		r.dst_dev    = (act != ACT_NONE) ? 3'(d) : 3'd0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  = MODE_UNINIT;
			valid_q = '0;
			alloc_q = '0;
			wlock_q = '0;
			for (int i = 0; i < NUM_DEVICES; i++) rcount_q[i] = '0;
			awaited_results.delete();
			fail_count   <= 0;
			results_owed <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result with nothing outstanding: status %0d action %0d",
							$time, status, action);
				end else begin
					head = awaited_results.pop_front();
					if (status !== head.status || action !== head.action ||
							need_alloc !== head.need_alloc || src_dev !== head.src_dev ||
							dst_dev !== head.dst_dev) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"%0t: mismatch status/action/need_alloc/src/dst ",
								"expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d"},
								$time, head.status, head.action, head.need_alloc,
								head.src_dev, head.dst_dev,
								status, action, need_alloc, src_dev, dst_dev);
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_lock_outcome(cmd, dev, new_mode, fresh);
				awaited_results.push_back(fresh);
			end
			fail_count   <= mismatches;
			results_owed <= awaited_results.size();
		end
	end

endmodule

@@ sim/tb_multi_device_coherence_lock_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_device_coherence_lock_tracker
// Drives lock, unlock, uncache and mode commands into the coherence lock
// tracker: a directed walk through every action and all statuses bar overflow,
// random lock sessions mixed with broken sequences, then a read-lock saturation
// burst. Both channels idle and stall at random; the checker by the block judges.
// ----------------------------------------------------------------------------
module tb_multi_device_coherence_lock_tracker;
	import mdclt_pkg::*;

	// commands outside the defined set; the block must refuse them
	localparam logic [2:0] CMD_UNKNOWN_A = 3'd6;
	localparam logic [2:0] CMD_UNKNOWN_B = 3'd7;
	// new_mode encodings for set mode
	localparam logic NM_UNINIT  = 1'b0;
	localparam logic NM_UNIFORM = 1'b1;
	localparam logic [2:0] CPU_DEV = 3'd0;

	localparam int RCOUNT_FULL  = (1 << READ_COUNT_BITS) - 1;
	localparam int RANDOM_ITEMS = 160;
	localparam int IDLE_PCT     = 14;
	// cycle windows: a stretch with no idling on either side, two long holds
	localparam int CALM_FROM    = 500;
	localparam int CALM_TO      = 900;
	localparam int HOLD_AT_A    = 300;
	localparam int HOLD_AT_B    = 1000;
	localparam int HOLD_LEN     = 80;
	localparam int DRAIN_CYCLES = 10;
	localparam int TIMEOUT_NS   = 2_000_000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] cmd;
	logic [2:0] dev;
	logic       new_mode;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] status;
	logic [2:0] action;
	logic       need_alloc;
	logic [2:0] src_dev;
	logic [2:0] dst_dev;
	int         fail_count;
	int         results_owed;

	int cyc = 0;	// free-running cycle count, updated after each edge
	int sent = 0;	// accepted input transactions
	wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	multi_device_coherence_lock_tracker DUT (.*);

	mdclt_lock_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	// Output side: random stall outside the calm window. At two fixed points
	// it holds the stall high until its hold counter runs out, so the block fills and stalls its input.
	initial begin : result_sink
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0 && (cyc == HOLD_AT_A || cyc == HOLD_AT_B)) hold = HOLD_LEN;
			if (hold != 0) begin
				hold--;
				out_stall <= 1'b1;
			end else
				out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	function automatic logic [2:0] rnd_dev();
		return 3'($urandom_range(0, 7));
	endfunction

	function automatic logic rnd_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// One transaction: optional idle cycles first, then hold it until taken.
	// Valid is decided without looking at stall.
	task automatic send_txn(input logic [2:0] c, input logic [2:0] d, input logic m);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		dev      <= d;
		new_mode <= m;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	// An out-of-turn command dropped into a lock session. Lock attempts are
	// paired with their unlock so no lock can be left behind.
	task automatic intrude();
		logic [2:0] x;
		x = rnd_dev();
		case ($urandom_range(0, 3))
			0: begin
				send_txn(CMD_RLOCK, x, rnd_bit());
				send_txn(CMD_RUNLOCK, x, rnd_bit());
			end
			1: begin
				send_txn(CMD_WLOCK, x, rnd_bit());
				send_txn(CMD_WUNLOCK, x, rnd_bit());
			end
			2: send_txn(CMD_SETMODE, x, rnd_bit());
			default: send_txn(CMD_UNCACHE, x, rnd_bit());
		endcase
	endtask

	// 1..3 read locks, maybe an intruder, then the matching unlocks in reverse
	task automatic read_session();
		logic [2:0] held [3];
		int n, k;
		n = $urandom_range(1, 3);
		for (k = 0; k < n; k++) begin
			held[k] = rnd_dev();
			send_txn(CMD_RLOCK, held[k], rnd_bit());
		end
		if ($urandom_range(0, 99) < 25) intrude();
		for (k = n - 1; k >= 0; k--) send_txn(CMD_RUNLOCK, held[k], rnd_bit());
	endtask

	task automatic write_session();
		logic [2:0] d;
		d = rnd_dev();
		send_txn(CMD_WLOCK, d, rnd_bit());
		if ($urandom_range(0, 99) < 30) intrude();
		send_txn(CMD_WUNLOCK, d, rnd_bit());
	endtask

	// broken traffic: stray unlocks, uncaches, mode changes, unknown commands
	task automatic noise_burst();
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 5))
				0: send_txn(CMD_RUNLOCK, rnd_dev(), rnd_bit());
				1: send_txn(CMD_WUNLOCK, rnd_dev(), rnd_bit());
				2: send_txn(CMD_UNCACHE, rnd_dev(), rnd_bit());
				3: send_txn(CMD_SETMODE, rnd_dev(), rnd_bit());
				4: send_txn(CMD_UNKNOWN_A, rnd_dev(), rnd_bit());
				default: send_txn(CMD_UNKNOWN_B, rnd_dev(), rnd_bit());
			endcase
		end
	endtask

	initial begin : stimulus
		logic [2:0] hot;
		int target, pick;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		cmd      = CMD_RLOCK;
		dev      = CPU_DEV;
		new_mode = NM_UNINIT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk, starting in uninitialized mode.
		send_txn(CMD_RLOCK, CPU_DEV, NM_UNINIT);	// allocate only, fresh arrays
		send_txn(CMD_RLOCK, 3'd7, NM_UNIFORM);		// allocate only, top device
		send_txn(CMD_WLOCK, 3'd3, NM_UNINIT);		// read locks held
		send_txn(CMD_SETMODE, 3'd2, NM_UNIFORM);	// refused under lock
		send_txn(CMD_RUNLOCK, CPU_DEV, NM_UNINIT);
		send_txn(CMD_RUNLOCK, CPU_DEV, NM_UNINIT);	// count already zero
		send_txn(CMD_RUNLOCK, 3'd7, NM_UNINIT);
		send_txn(CMD_SETMODE, 3'd6, NM_UNIFORM);	// uniform, all copies invalid
		send_txn(CMD_RLOCK, 3'd2, NM_UNINIT);		// uniform fill
		send_txn(CMD_RUNLOCK, 3'd2, NM_UNINIT);
		send_txn(CMD_WLOCK, 3'd2, NM_UNINIT);		// already valid; mode goes to data
		send_txn(CMD_RLOCK, 3'd4, NM_UNINIT);		// blocked by the write lock
		send_txn(CMD_WUNLOCK, 3'd4, NM_UNINIT);		// copy not valid
		send_txn(CMD_WUNLOCK, 3'd2, NM_UNINIT);
		send_txn(CMD_WUNLOCK, 3'd2, NM_UNINIT);		// no write lock to drop
		send_txn(CMD_RLOCK, 3'd5, NM_UNINIT);		// device to device copy: unsupported
		send_txn(CMD_RLOCK, CPU_DEV, NM_UNINIT);	// copy into CPU, arrays kept
		send_txn(CMD_RLOCK, 3'd5, NM_UNINIT);		// copy from CPU
		send_txn(CMD_UNCACHE, CPU_DEV, NM_UNINIT);	// CPU holds a read lock
		send_txn(CMD_RUNLOCK, CPU_DEV, NM_UNINIT);
		send_txn(CMD_RUNLOCK, 3'd5, NM_UNINIT);
		send_txn(CMD_UNCACHE, CPU_DEV, NM_UNINIT);	// free, others still valid
		send_txn(CMD_UNCACHE, 3'd6, NM_UNINIT);		// nothing allocated, no action
		send_txn(CMD_UNCACHE, 3'd2, NM_UNINIT);
		send_txn(CMD_UNCACHE, 3'd5, NM_UNINIT);		// last valid copy of data
		send_txn(CMD_UNKNOWN_A, 3'd7, NM_UNIFORM);
		send_txn(CMD_UNKNOWN_B, CPU_DEV, NM_UNINIT);
		send_txn(CMD_SETMODE, 3'd1, NM_UNINIT);

		// Random part: mostly well-formed lock sessions with random devices.
		target = sent + RANDOM_ITEMS;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) read_session();
			else if (pick < 70) write_session();
			else if (pick < 80) send_txn(CMD_SETMODE, rnd_dev(), rnd_bit());
			else if (pick < 90) send_txn(CMD_UNCACHE, rnd_dev(), rnd_bit());
			else noise_burst();
		end

		// Saturate one read-lock count and poke at it. No lock is held here,
		// so the mode change goes through and the read locks succeed until the count is full.
		send_txn(CMD_SETMODE, CPU_DEV, NM_UNIFORM);
		hot = rnd_dev();
		repeat (RCOUNT_FULL + 2) send_txn(CMD_RLOCK, hot, rnd_bit());
		send_txn(CMD_WLOCK, rnd_dev(), NM_UNINIT);
		send_txn(CMD_SETMODE, rnd_dev(), NM_UNIFORM);

		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#TIMEOUT_NS;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mdclt_pkg.sv
hw/rtl/mdclt_ctrl.sv
hw/rtl/mdclt_dp.sv
hw/rtl/multi_device_coherence_lock_tracker.sv
hw/rtl/mdclt_chk.sv
sim/mdclt_lock_checker.sv
sim/tb_multi_device_coherence_lock_tracker.sv
